// ===== hdl/egbm_pkg.sv =====
// shared types, constants and rounding helpers of the euler gbm path payoff block
package egbm_pkg;

   localparam int VAL_W       = 32;
   localparam int UVAL_W      = 31;
   localparam int COEF_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int STEP_W      = 16;
   localparam int HIT_W       = 16;
   localparam int TOT_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MA_W        = 34;
   localparam int MB_W        = 33;
   localparam int PROD_W      = MA_W + MB_W;
   localparam int FRAC_COEF   = 30;
   localparam int FRAC_SAMPLE = 12;
   localparam int A_W         = 34;
   localparam int C_W         = 38;
   localparam int SUM_W       = 40;
   localparam int PAY_W       = 34;
   localparam int MAX_STEPS   = 65535;

   localparam logic [UVAL_W-1:0] START_VALUE_RST = 31'd6553600;
   localparam logic [UVAL_W-1:0] STRIKE_RST      = 31'd6553600;
   localparam logic [COEF_W-1:0] DRIFT_COEF_RST  = 32'd0;
   localparam logic [UVAL_W-1:0] DIFF_COEF_RST   = 31'd21474836;
   localparam logic [STEP_W-1:0] STEPS_RST       = 16'd100;

   localparam logic signed [PROD_W-1:0] HALF_COEF   = PROD_W'(64'd1 << (FRAC_COEF - 1));
   localparam logic signed [PROD_W-1:0] HALF_SAMPLE = PROD_W'(64'd1 << (FRAC_SAMPLE - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_VALUE    = 3'd0,
      CSR_STRIKE         = 3'd1,
      CSR_DRIFT_COEF     = 3'd2,
      CSR_DIFF_COEF      = 3'd3,
      CSR_STEPS_PER_PATH = 3'd4,
      CSR_OPTION_TYPE    = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ROUND_B,
      ST_MUL_C,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      OP_DRIFT,
      OP_DIFF,
      OP_SAMPLE
   } op_sel_type;

   typedef struct packed {
      logic [UVAL_W-1:0]        start_value;
      logic [UVAL_W-1:0]        strike;
      logic signed [COEF_W-1:0] drift_coef;
      logic [UVAL_W-1:0]        diff_coef;
      logic [STEP_W-1:0]        steps_per_path;
      logic                     option_type;
   } cfg_type;

   typedef struct packed {
      logic       req_ready;
      logic       mul_en;
      op_sel_type op_sel;
      logic       load_a;
      logic       load_b;
      logic       update;
   } ctl_type;

   // round to nearest, ties up, by 2^30
   function automatic logic signed [A_W-1:0] round_coef(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + HALF_COEF;
      return t[FRAC_COEF+A_W-1:FRAC_COEF];
   endfunction

   // round to nearest, ties up, by 2^12
   function automatic logic signed [C_W-1:0] round_sample(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + HALF_SAMPLE;
      return t[FRAC_SAMPLE+C_W-1:FRAC_SAMPLE];
   endfunction

endpackage

// ===== hdl/egbm_if.sv =====
// valid/ready channel interfaces for samples and path results
interface egbm_req_if import egbm_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] normal_sample;

   modport source (output valid, output normal_sample, input ready);
   modport sink (input valid, input normal_sample, output ready);
endinterface

interface egbm_rsp_if import egbm_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [UVAL_W-1:0]        payoff;
   logic signed [VAL_W-1:0]  final_value;
   logic [HIT_W-1:0]         path_hits;
   logic [TOT_W-1:0]         total_hits;

   modport source (output valid, output payoff, output final_value, output path_hits,
                   output total_hits, input ready);
   modport sink (input valid, input payoff, input final_value, input path_hits,
                 input total_hits, output ready);
endinterface

// ===== hdl/egbm_csr.sv =====
// configuration register file
module egbm_csr import egbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_VALUE:    cfg_in.start_value    = csr_wr_data[UVAL_W-1:0];
            CSR_STRIKE:         cfg_in.strike         = csr_wr_data[UVAL_W-1:0];
            CSR_DRIFT_COEF:     cfg_in.drift_coef     = signed'(csr_wr_data[COEF_W-1:0]);
            CSR_DIFF_COEF:      cfg_in.diff_coef      = csr_wr_data[UVAL_W-1:0];
            CSR_STEPS_PER_PATH: cfg_in.steps_per_path = csr_wr_data[STEP_W-1:0];
            CSR_OPTION_TYPE:    cfg_in.option_type    = csr_wr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value    <= START_VALUE_RST;
         cfg_ff.strike         <= STRIKE_RST;
         cfg_ff.drift_coef     <= DRIFT_COEF_RST;
         cfg_ff.diff_coef      <= DIFF_COEF_RST;
         cfg_ff.steps_per_path <= STEPS_RST;
         cfg_ff.option_type    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/egbm_mul.sv =====
// shared signed multiplier with registered product
module egbm_mul import egbm_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [MA_W-1:0]   op_a,
   input  logic signed [MB_W-1:0]   op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/egbm_ctrl.sv =====
// step sequencer driving the shared multiplier
module egbm_ctrl import egbm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    update_go,
   output ctl_type ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctl.req_ready = 1'b0;
      ctl.mul_en    = 1'b0;
      ctl.op_sel    = OP_DRIFT;
      ctl.load_a    = 1'b0;
      ctl.load_b    = 1'b0;
      ctl.update    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            ctl.mul_en = 1'b1;
            ctl.op_sel = OP_DRIFT;
            state_in   = ST_MUL_B;
         end
         ST_MUL_B: begin
            ctl.mul_en = 1'b1;
            ctl.op_sel = OP_DIFF;
            ctl.load_a = 1'b1;
            state_in   = ST_ROUND_B;
         end
         ST_ROUND_B: begin
            ctl.load_b = 1'b1;
            state_in   = ST_MUL_C;
         end
         ST_MUL_C: begin
            ctl.mul_en = 1'b1;
            ctl.op_sel = OP_SAMPLE;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctl.update = 1'b1;
            // wait here while this step ends a path and a finished path still sits untaken in the output register
            if (update_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hdl/euler_gbm_path_payoff_top.sv =====
// top level: euler-maruyama gbm path with call/put payoff
// One normal sample advances the asset value by one Euler step. A step runs through the
// accepting idle state, three passes through one shared 34x33 signed multiplier for
// drift*v, diffusion*v and the diffusion term times the sample, a rounding state between
// the last two passes, and the state update. A steps_per_path of zero counts as one.
// After steps_per_path steps the payoff, final value and hit counts are loaded into an
// output register. The next sample is accepted while that result waits. Only the update of
// a step that ends a path holds until the previous result has been taken.
module euler_gbm_path_payoff_top import egbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   egbm_req_if.sink              req_chan,
   egbm_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type                  cfg;
   ctl_type                  ctl;
   logic signed [PROD_W-1:0] prod;
   logic signed [MA_W-1:0]   op_a;
   logic signed [MB_W-1:0]   op_b;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [A_W-1:0]      a_ff;
   logic signed [A_W-1:0]      b_ff;
   logic signed [VAL_W-1:0]    asset_ff, asset_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [HIT_W-1:0]           hits_ff, hits_in;
   logic [TOT_W-1:0]           total_ff, total_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [UVAL_W-1:0]       payoff_ff;
   logic signed [VAL_W-1:0] final_ff;
   logic [HIT_W-1:0]        path_hits_ff;
   logic [TOT_W-1:0]        total_hits_ff;

   logic signed [C_W-1:0]   c_w;
   logic signed [SUM_W-1:0] sum_w;
   logic signed [VAL_W-1:0] new_val;
   logic                    nonpos;
   logic [HIT_W-1:0]        hits_next;
   logic [TOT_W-1:0]        total_next;
   logic [STEP_W-1:0]       step_next;
   logic [STEP_W-1:0]       len_eff;
   logic                    path_end;
   logic signed [PAY_W-1:0] pay_diff;
   logic [UVAL_W-1:0]       pay_val;
   logic                    update_go;
   logic                    req_fire;
   logic                    step_done;

   egbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   egbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .update_go (update_go),
      .ctl       (ctl)
   );

   always_comb begin
      case (ctl.op_sel)
         OP_DRIFT: begin
            op_a = MA_W'(cfg.drift_coef);
            op_b = MB_W'(asset_ff);
         end
         OP_DIFF: begin
            op_a = signed'(MA_W'(cfg.diff_coef));
            op_b = MB_W'(asset_ff);
         end
         OP_SAMPLE: begin
            op_a = b_ff;
            op_b = MB_W'(sample_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   egbm_mul u_mul (
      .clock (clock),
      .en    (ctl.mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_chan.ready = ctl.req_ready;
   assign req_fire       = req_chan.valid & ctl.req_ready;

   // step update, valid in the update state when prod holds b*sample
   always_comb begin
      c_w   = round_sample(prod);
      sum_w = SUM_W'(asset_ff) + SUM_W'(a_ff) + SUM_W'(c_w);
      if (sum_w > SUM_W'(signed'(32'h7FFF_FFFF))) begin
         new_val = signed'(32'h7FFF_FFFF);
      end else if (sum_w < SUM_W'(signed'(32'h8000_0000))) begin
         new_val = signed'(32'h8000_0000);
      end else begin
         new_val = sum_w[VAL_W-1:0];
      end
      nonpos     = (new_val <= 0);
      hits_next  = (nonpos && hits_ff != '1) ? hits_ff + 1'b1 : hits_ff;
      total_next = (nonpos && total_ff != '1) ? total_ff + 1'b1 : total_ff;
      step_next  = (step_ff != '1) ? step_ff + 1'b1 : step_ff;
      if (cfg.steps_per_path == '0) begin
         len_eff = STEP_W'(1);
      end else if (32'(cfg.steps_per_path) > 32'(MAX_STEPS)) begin
         len_eff = STEP_W'(MAX_STEPS);
      end else begin
         len_eff = cfg.steps_per_path;
      end
      path_end = (step_next >= len_eff);
      if (cfg.option_type) begin
         pay_diff = PAY_W'(signed'({1'b0, cfg.strike})) - PAY_W'(new_val);
      end else begin
         pay_diff = PAY_W'(new_val) - PAY_W'(signed'({1'b0, cfg.strike}));
      end
      if (pay_diff < 0) begin
         pay_val = '0;
      end else if (pay_diff > PAY_W'(signed'(32'h7FFF_FFFF))) begin
         pay_val = '1;
      end else begin
         pay_val = pay_diff[UVAL_W-1:0];
      end
      update_go = !path_end || !rsp_valid_ff || rsp_chan.ready;
      step_done = ctl.update && update_go;
   end

   always_comb begin
      asset_in = asset_ff;
      step_in  = step_ff;
      hits_in  = hits_ff;
      total_in = total_ff;
      if (step_done) begin
         total_in = total_next;
         if (path_end) begin
            asset_in = signed'({1'b0, cfg.start_value});
            step_in  = '0;
            hits_in  = '0;
         end else begin
            asset_in = new_val;
            step_in  = step_next;
            hits_in  = hits_next;
         end
      end
      if (step_done && path_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asset_ff     <= signed'({1'b0, START_VALUE_RST});
         step_ff      <= '0;
         hits_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         asset_ff     <= asset_in;
         step_ff      <= step_in;
         hits_ff      <= hits_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_chan.normal_sample;
      end
      if (ctl.load_a) begin
         a_ff <= round_coef(prod);
      end
      if (ctl.load_b) begin
         b_ff <= round_coef(prod);
      end
      if (step_done && path_end) begin
         payoff_ff     <= pay_val;
         final_ff      <= new_val;
         path_hits_ff  <= hits_next;
         total_hits_ff <= total_next;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.payoff      = payoff_ff;
   assign rsp_chan.final_value = final_ff;
   assign rsp_chan.path_hits   = path_hits_ff;
   assign rsp_chan.total_hits  = total_hits_ff;

   // a path never counts more hits than steps taken
   assert property (@(posedge clock) disable iff (reset) 32'(hits_ff) <= 32'(step_ff))
      else $error("path hit count exceeds step count");

   // the running total always covers the running path
   assert property (@(posedge clock) disable iff (reset) 32'(hits_ff) <= total_ff)
      else $error("total hit count below path hit count");

   // a result only appears from a completed update step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.update && update_go))
      else $error("result raised outside an update step");

   // a pending result is never overwritten by a path end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !(step_done && path_end))
      else $error("pending result overwritten");

endmodule
